/* hw/rtl/vtva_pkg.sv */
// Shared types, constants and helper functions of the view angle block.
package vtva_pkg;

   // Input component width and the scaling applied before the CORDIC.
   localparam int VEC_WIDTH   = 24;
   localparam int VEC_SCALE   = 16;
   // CORDIC datapath widths: vector words and angle accumulators (2^-15 degree).
   localparam int XY_WIDTH    = 44;
   localparam int ACC_WIDTH   = 25;
   // Wrapped angle in 1/128 degree, 0 to 360 degrees.
   localparam int ANG_WIDTH   = 17;
   localparam int PITCH_WIDTH = 15;
   localparam int YAW_WIDTH   = 16;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_ENTRIES         = 24;

   // Inverse CORDIC gain in Q20.
   localparam int GAIN_WIDTH = 20;
   localparam int GAIN_FRAC  = 20;
   localparam int INV_GAIN   = 636751;

   localparam logic signed [ACC_WIDTH-1:0] ACC_90 = ACC_WIDTH'(2949120);

   localparam int DEG128_89  = 89 * 128;
   localparam int DEG128_90  = 90 * 128;
   localparam int DEG128_180 = 180 * 128;
   localparam int DEG128_270 = 270 * 128;
   localparam int DEG128_360 = 360 * 128;
   localparam int DEG128_540 = 540 * 128;
   localparam int DEG128_720 = 720 * 128;

   typedef struct packed {
      logic                          valid;
      logic                          zero_h;
      logic signed [VEC_WIDTH-1:0]   z;
      logic        [ANG_WIDTH-1:0]   yaw;
      logic signed [XY_WIDTH-1:0]    x;
      logic signed [XY_WIDTH-1:0]    y;
      logic signed [ACC_WIDTH-1:0]   acc;
   } cordic_type;

   typedef struct packed {
      logic signed [PITCH_WIDTH-1:0] pitch_deg;
      logic signed [YAW_WIDTH-1:0]   yaw_deg;
   } rsp_type;

   // round(atan(2^-i) * 180/pi * 2^15)
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input int idx);
      logic signed [ACC_WIDTH-1:0] value;
      case (idx)
         0:  value = ACC_WIDTH'(1474560);
         1:  value = ACC_WIDTH'(870484);
         2:  value = ACC_WIDTH'(459940);
         3:  value = ACC_WIDTH'(233473);
         4:  value = ACC_WIDTH'(117189);
         5:  value = ACC_WIDTH'(58652);
         6:  value = ACC_WIDTH'(29333);
         7:  value = ACC_WIDTH'(14667);
         8:  value = ACC_WIDTH'(7334);
         9:  value = ACC_WIDTH'(3667);
         10: value = ACC_WIDTH'(1833);
         11: value = ACC_WIDTH'(917);
         12: value = ACC_WIDTH'(458);
         13: value = ACC_WIDTH'(229);
         14: value = ACC_WIDTH'(115);
         15: value = ACC_WIDTH'(57);
         16: value = ACC_WIDTH'(29);
         17: value = ACC_WIDTH'(14);
         18: value = ACC_WIDTH'(7);
         19: value = ACC_WIDTH'(4);
         20: value = ACC_WIDTH'(2);
         21: value = ACC_WIDTH'(1);
         default: value = '0;
      endcase
      return value;
   endfunction

   // Rounds an accumulator to 1/128 degree and wraps negative angles into 0..360.
   function automatic logic [ANG_WIDTH-1:0] acc_to_angle(input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-1:0] rounded;
      logic signed [ANG_WIDTH:0]   angle;
      rounded = acc + ACC_WIDTH'(128);
      angle   = {rounded[ACC_WIDTH-1], rounded[ACC_WIDTH-1:8]};
      if (angle[ANG_WIDTH]) begin
         angle = angle + (ANG_WIDTH + 1)'(DEG128_360);
      end
      return angle[ANG_WIDTH-1:0];
   endfunction

endpackage

/* hw/rtl/vtva_if.sv */
// Handshake channel interfaces for direction vectors and view angle results.
interface vtva_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [vtva_pkg::VEC_WIDTH-1:0]  vec_x;
   logic signed [vtva_pkg::VEC_WIDTH-1:0]  vec_y;
   logic signed [vtva_pkg::VEC_WIDTH-1:0]  vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface vtva_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [vtva_pkg::PITCH_WIDTH-1:0] pitch_deg;
   logic signed [vtva_pkg::YAW_WIDTH-1:0]   yaw_deg;

   modport source (output valid, output pitch_deg, output yaw_deg, input ready);
   modport sink   (input valid, input pitch_deg, input yaw_deg, output ready);
endinterface

/* hw/rtl/vector_to_view_angles.sv */
// Top level of the direction vector to pitch and yaw converter.

// This block turns a signed 24-bit direction vector (x forward, y sideways, z
// vertical) into view angles in units of 1/128 degree: yaw = atan2(y, x) and
// pitch = atan2(-z, r), with r the horizontal length, both found by vectoring
// CORDIC with CORDIC_STEPS iterations (values above 24 act as 24).  Pitch
// above 89 degrees is folded back by 180 degrees with yaw turned by 180, or
// above 269 degrees by 360 with yaw turned by 360, and yaw is then wrapped to
// -180..180; a vector with no horizontal part gives a pitch of -90 degrees
// with yaw 0 when z is positive, and yaw 180 otherwise.  The pipeline takes
// one transaction per clock cycle while request ready is high and gives one
// result per transaction, in order.  A transaction passes 2 * CORDIC_STEPS + 6
// registers: one input stage, one register per CORDIC iteration for yaw and
// again for pitch, two stages for the inverse gain multiply, two for rounding
// and normalisation and the output register.  The input stage loads at the
// accepting edge, so the result reaches the response channel once it has passed
// these registers and, with ready held high, is taken at the following edge.  The pitch CORDIC
// cannot start before the yaw CORDIC has produced the horizontal length, which
// is what sets the depth.  A stalled response channel is absorbed by a
// one-entry skid buffer; request ready is registered and drops only while that
// buffer holds a result, at which point the whole pipeline holds its contents.
module vector_to_view_angles #(
   parameter int CORDIC_STEPS = vtva_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   vtva_req_if.sink          req_chan,
   vtva_rsp_if.source        rsp_chan
);

   localparam int STEPS = (CORDIC_STEPS > vtva_pkg::ATAN_ENTRIES) ?
                          vtva_pkg::ATAN_ENTRIES : CORDIC_STEPS;
   localparam int XW    = vtva_pkg::XY_WIDTH;
   localparam int VW    = vtva_pkg::VEC_WIDTH;
   localparam int SC    = vtva_pkg::VEC_SCALE;

   logic pipe_en;

   vtva_pkg::cordic_type pre_in;
   vtva_pkg::cordic_type pre_ff;
   vtva_pkg::cordic_type yaw_chain   [0:STEPS];
   vtva_pkg::cordic_type pitch_chain [0:STEPS];

   logic signed [XW-1:0] cx;
   logic signed [XW-1:0] cy;

   logic              last_valid;
   vtva_pkg::rsp_type last_data;

   logic              out_valid_in;
   logic              out_valid_ff;
   vtva_pkg::rsp_type out_in;
   vtva_pkg::rsp_type out_ff;
   logic              skid_valid_in;
   logic              skid_valid_ff;
   vtva_pkg::rsp_type skid_in;
   vtva_pkg::rsp_type skid_ff;
   logic              rsp_take;

   // The whole pipeline advances together whenever the skid buffer is free.
   assign pipe_en        = !skid_valid_ff;
   assign req_chan.ready = pipe_en;

   // Input stage: scale the components and pre-rotate a vector with negative x
   // by a quarter turn, so that the yaw CORDIC starts in the right half plane.
   always_comb begin
      cx = {{(XW-VW-SC){req_chan.vec_x[VW-1]}}, req_chan.vec_x, {SC{1'b0}}};
      cy = {{(XW-VW-SC){req_chan.vec_y[VW-1]}}, req_chan.vec_y, {SC{1'b0}}};

      pre_in.valid  = req_chan.valid;
      pre_in.zero_h = (req_chan.vec_x == '0) && (req_chan.vec_y == '0);
      pre_in.z      = req_chan.vec_z;
      pre_in.yaw    = '0;
      pre_in.x      = cx;
      pre_in.y      = cy;
      pre_in.acc    = '0;
      if (req_chan.vec_x[VW-1]) begin
         if (!req_chan.vec_y[VW-1]) begin
            pre_in.x   = cy;
            pre_in.y   = -cx;
            pre_in.acc = vtva_pkg::ACC_90;
         end else begin
            pre_in.x   = -cy;
            pre_in.y   = cx;
            pre_in.acc = -vtva_pkg::ACC_90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
      end else if (pipe_en) begin
         pre_ff <= pre_in;
      end
   end

   assign yaw_chain[0] = pre_ff;

   // Yaw CORDIC, one register stage per iteration.
   for (genvar i = 0; i < STEPS; i++) begin : g_yaw
      vtva_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .stage_i (yaw_chain[i]),
         .stage_o (yaw_chain[i+1])
      );
   end

   // Gain correction gives r and sets up the pitch CORDIC on (r, -z).
   vtva_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .stage_i (yaw_chain[STEPS]),
      .stage_o (pitch_chain[0])
   );

   // Pitch CORDIC, one register stage per iteration.
   for (genvar i = 0; i < STEPS; i++) begin : g_pitch
      vtva_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .stage_i (pitch_chain[i]),
         .stage_o (pitch_chain[i+1])
      );
   end

   vtva_post u_post (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .stage_i (pitch_chain[STEPS]),
      .valid_o (last_valid),
      .data_o  (last_data)
   );

   // Output register with a skid buffer behind it.  The pipeline moves in a
   // cycle where the skid buffer is empty; a result arriving while the output
   // register is still waiting for its transaction is parked in the skid
   // buffer, which freezes the pipeline until the output drains.
   assign rsp_take = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take || !out_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (last_valid) begin
         if (rsp_take || !out_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = last_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = last_data;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pitch_deg = out_ff.pitch_deg;
   assign rsp_chan.yaw_deg   = out_ff.yaw_deg;

endmodule

/* hw/rtl/vtva_cordic_stage.sv */
// One registered vectoring CORDIC iteration.
module vtva_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vtva_pkg::cordic_type   stage_i,
   output vtva_pkg::cordic_type   stage_o
);

   localparam logic signed [vtva_pkg::ACC_WIDTH-1:0] ANGLE = vtva_pkg::atan_entry(STEP);

   vtva_pkg::cordic_type            stage_in;
   vtva_pkg::cordic_type            stage_ff;
   logic signed [vtva_pkg::XY_WIDTH-1:0] dx;
   logic signed [vtva_pkg::XY_WIDTH-1:0] dy;

   always_comb begin
      dx       = stage_i.y >>> STEP;
      dy       = stage_i.x >>> STEP;
      stage_in = stage_i;
      if (!stage_i.y[vtva_pkg::XY_WIDTH-1]) begin
         stage_in.x   = stage_i.x + dx;
         stage_in.y   = stage_i.y - dy;
         stage_in.acc = stage_i.acc + ANGLE;
      end else begin
         stage_in.x   = stage_i.x - dx;
         stage_in.y   = stage_i.y + dy;
         stage_in.acc = stage_i.acc - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* hw/rtl/vtva_gain.sv */
// Yaw rounding and inverse gain correction that turns the yaw CORDIC length into r.
module vtva_gain (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vtva_pkg::cordic_type   stage_i,
   output vtva_pkg::cordic_type   stage_o
);

   localparam int XW    = vtva_pkg::XY_WIDTH;
   localparam int LO_W  = 21;
   localparam int HI_W  = XW - LO_W;
   localparam int GW    = vtva_pkg::GAIN_WIDTH;
   localparam int PL_W  = LO_W + GW;
   localparam int PH_W  = HI_W + GW + 1;
   localparam int SUM_W = XW + GW + 1;

   localparam logic        [GW-1:0] GAIN_U = GW'(vtva_pkg::INV_GAIN);
   localparam logic signed [GW:0]   GAIN_S = (GW + 1)'(vtva_pkg::INV_GAIN);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (vtva_pkg::GAIN_FRAC - 1);

   typedef struct packed {
      logic                                 valid;
      logic                                 zero_h;
      logic signed [vtva_pkg::VEC_WIDTH-1:0] z;
      logic        [vtva_pkg::ANG_WIDTH-1:0] yaw;
      logic        [PL_W-1:0]               lo;
      logic signed [PH_W-1:0]               hi;
   } product_type;

   product_type          prod_in;
   product_type          prod_ff;
   vtva_pkg::cordic_type len_in;
   vtva_pkg::cordic_type len_ff;

   logic signed [SUM_W-1:0] hi_ext;
   logic signed [SUM_W-1:0] lo_ext;
   logic signed [SUM_W-1:0] sum;
   logic signed [XW-1:0]    z_scaled;

   // The length is split into two partial products to keep each multiplier narrow.
   always_comb begin
      prod_in.valid  = stage_i.valid;
      prod_in.zero_h = stage_i.zero_h;
      prod_in.z      = stage_i.z;
      prod_in.yaw    = vtva_pkg::acc_to_angle(stage_i.acc);
      prod_in.lo     = PL_W'(stage_i.x[LO_W-1:0]) * PL_W'(GAIN_U);
      prod_in.hi     = PH_W'($signed(stage_i.x[XW-1:LO_W])) * PH_W'(GAIN_S);
   end

   always_comb begin
      hi_ext   = {{(SUM_W-PH_W){prod_ff.hi[PH_W-1]}}, prod_ff.hi};
      lo_ext   = {{(SUM_W-PL_W){1'b0}}, prod_ff.lo};
      sum      = (hi_ext <<< LO_W) + lo_ext + ROUND_HALF;
      z_scaled = {{(XW-vtva_pkg::VEC_WIDTH-vtva_pkg::VEC_SCALE){prod_ff.z[vtva_pkg::VEC_WIDTH-1]}},
                  prod_ff.z, {vtva_pkg::VEC_SCALE{1'b0}}};

      len_in.valid  = prod_ff.valid;
      len_in.zero_h = prod_ff.zero_h;
      len_in.z      = prod_ff.z;
      len_in.yaw    = prod_ff.yaw;
      len_in.x      = sum[vtva_pkg::GAIN_FRAC+XW-1:vtva_pkg::GAIN_FRAC];
      len_in.y      = -z_scaled;
      len_in.acc    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
         len_ff  <= '0;
      end else if (en) begin
         prod_ff <= prod_in;
         len_ff  <= len_in;
      end
   end

   assign stage_o = len_ff;

endmodule

/* hw/rtl/vtva_post.sv */
// Pitch rounding, vertical vector handling and the final angle normalisation.
module vtva_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vtva_pkg::cordic_type   stage_i,
   output logic                   valid_o,
   output vtva_pkg::rsp_type      data_o
);

   localparam int AW = vtva_pkg::ANG_WIDTH;

   typedef struct packed {
      logic          valid;
      logic [AW-1:0] pitch;
      logic [AW-1:0] yaw;
   } angle_type;

   angle_type          angle_in;
   angle_type          angle_ff;
   logic               out_valid_ff;
   vtva_pkg::rsp_type  out_in;
   vtva_pkg::rsp_type  out_ff;

   logic signed [AW:0] pitch_s;
   logic        [AW-1:0] yaw_t;
   logic signed [AW:0] yaw_s;

   always_comb begin
      angle_in.valid = stage_i.valid;
      angle_in.pitch = vtva_pkg::acc_to_angle(stage_i.acc);
      angle_in.yaw   = stage_i.yaw;
      // With no horizontal part the pitch points straight up or down.
      if (stage_i.zero_h) begin
         angle_in.yaw = '0;
         if (!stage_i.z[vtva_pkg::VEC_WIDTH-1] && (stage_i.z != '0)) begin
            angle_in.pitch = AW'(vtva_pkg::DEG128_270);
         end else begin
            angle_in.pitch = AW'(vtva_pkg::DEG128_90);
         end
      end
   end

   // Pitch above 89 degrees folds over by 180 once or twice, each fold turning yaw by 180.
   always_comb begin
      pitch_s = {1'b0, angle_ff.pitch};
      yaw_t   = angle_ff.yaw;
      if (angle_ff.pitch > AW'(vtva_pkg::DEG128_89 + vtva_pkg::DEG128_360 / 2)) begin
         pitch_s = pitch_s - (AW + 1)'(vtva_pkg::DEG128_360);
         yaw_t   = angle_ff.yaw + AW'(vtva_pkg::DEG128_360);
      end else if (angle_ff.pitch > AW'(vtva_pkg::DEG128_89)) begin
         pitch_s = pitch_s - (AW + 1)'(vtva_pkg::DEG128_180);
         yaw_t   = angle_ff.yaw + AW'(vtva_pkg::DEG128_180);
      end

      yaw_s = {1'b0, yaw_t};
      if (yaw_t > AW'(vtva_pkg::DEG128_540)) begin
         yaw_s = yaw_s - (AW + 1)'(vtva_pkg::DEG128_720);
      end else if (yaw_t > AW'(vtva_pkg::DEG128_180)) begin
         yaw_s = yaw_s - (AW + 1)'(vtva_pkg::DEG128_360);
      end

      out_in.pitch_deg = pitch_s[vtva_pkg::PITCH_WIDTH-1:0];
      out_in.yaw_deg   = yaw_s[vtva_pkg::YAW_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
      end else if (en) begin
         angle_ff     <= angle_in;
         out_valid_ff <= angle_ff.valid;
         out_ff       <= out_in;
      end
   end

   assign valid_o = out_valid_ff;
   assign data_o  = out_ff;

endmodule
